// ----- hw/rtl/lcdnum_pkg.sv -----
// Package for the LCD number display writer.
// Holds the request kind codes, LCD command and ASCII constants, and digit-to-character mapping.
// No dependencies.
package lcdnum_pkg;

  // Default sizes
  localparam int unsigned MaxDigitsDef  = 16;
  localparam int unsigned ValueWidthDef = 16;

  // Request kinds
  typedef enum logic [1:0] {
    KIND_UDEC = 2'd0,
    KIND_SDEC = 2'd1,
    KIND_HEX  = 2'd2,
    KIND_BIN  = 2'd3
  } kind_e;

  // LCD command bits
  localparam logic [7:0] LCD_SET_DDRAM  = 8'h80;
  localparam logic [7:0] LCD_ROW2_OFFS  = 8'h40;

  // ASCII characters
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_A     = 8'h41;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [7:0] ASCII_PLUS  = 8'h2B;

  // Digit value 0..15 to ASCII, uppercase hex letters
  function automatic logic [7:0] digit_to_ascii(input logic [3:0] d);
    logic [7:0] ch;
    if (d < 4'd10) begin
      ch = ASCII_ZERO + {4'b0000, d};
    end else begin
      ch = ASCII_A + {4'b0000, d} - 8'd10;
    end
    return ch;
  endfunction

endpackage

// ----- hw/rtl/lcd_number_display_writer.sv -----
// Turns a number display request into a sequence of character LCD bus writes.
// Serial binary-to-decimal converter (shift and add-3), output register, small sequencer.
// Depends on lcdnum_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one request: kind, line, column,
//   value and digit count. The block holds in_stall_o high until every write of
//   that request has been loaded into the output register.
//   Output channel (out_valid_o / out_stall_i) gives one bus write per request
//   transfer: first the set-DDRAM-address command, then the sign for signed
//   decimal, then the digits, most significant first; last_o marks the final one.
//   A taken request moves the sequencer to the address state, which then loads
//   the address command into the output register. Decimal kinds convert one value
//   bit per cycle while the address and sign go out; hex and binary digits load
//   directly. With no digits a request writes only the address command, plus the
//   sign for signed decimal. The output register holds one write; while out_stall_i
//   is high the sequencer waits and the held write does not change.
//   Reset clears the sequencer and the output valid; no request is pending.
module lcd_number_display_writer
  import lcdnum_pkg::*;
#(
  parameter int unsigned MAX_DIGITS  = MaxDigitsDef,
  parameter int unsigned VALUE_WIDTH = ValueWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // request channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             kind_i,
  input  logic [1:0]             line_number_i,
  input  logic [5:0]             column_number_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic [4:0]             digit_count_i,
  // bus write channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   is_data_o,
  output logic [7:0]             bus_byte_o,
  output logic                   last_o
);

  localparam int unsigned CntW  = $clog2(MAX_DIGITS + 1);
  localparam int unsigned IdxW  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned ConvW = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned PadW  = VALUE_WIDTH + MAX_DIGITS;

  // Sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ADDR   = 2'd1;
  localparam logic [1:0] ST_SIGN   = 2'd2;
  localparam logic [1:0] ST_DIGITS = 2'd3;

  logic [1:0]                  state_q, state_d;
  kind_e                       kind_q;
  logic                        neg_q;
  logic [7:0]                  addr_q;
  logic [CntW-1:0]             dig_q, dig_d;
  logic [ConvW-1:0]            conv_cnt_q;
  logic [VALUE_WIDTH-1:0]      bin_q;
  logic [MAX_DIGITS-1:0][3:0]  bcd_q;

  logic                        out_valid_q;
  logic                        out_is_data_q;
  logic [7:0]                  out_byte_q;
  logic                        out_last_q;

  logic                        in_accept;
  logic                        slot_free;
  logic                        conv_done;
  logic                        emit;
  logic                        emit_data;
  logic [7:0]                  emit_byte;
  logic                        emit_last;

  // Request decode
  kind_e                       in_kind;
  logic                        in_neg;
  logic [VALUE_WIDTH-1:0]      in_mag;
  logic [CntW-1:0]             in_cnt;
  logic [7:0]                  in_addr;
  logic [PadW-1:0]             in_pad;
  logic [MAX_DIGITS-1:0][3:0]  in_nib;

  // Converter step
  logic [MAX_DIGITS-1:0][3:0]  corr;
  logic [MAX_DIGITS*4:0]       bcd_shift;
  logic [IdxW-1:0]             dig_idx;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign conv_done  = (conv_cnt_q == '0);

  always_comb begin
    in_kind = kind_e'(kind_i);
    in_neg  = (in_kind == KIND_SDEC) && value_i[VALUE_WIDTH-1];
    in_mag  = in_neg ? (~value_i + 1'b1) : value_i;
    if ({1'b0, digit_count_i} > 6'(MAX_DIGITS)) begin
      in_cnt = CntW'(MAX_DIGITS);
    end else begin
      in_cnt = CntW'(digit_count_i);
    end
    // column - 1 wraps modulo 256; any line other than one is row two
    in_addr = {2'b00, column_number_i} - 8'd1;
    if (line_number_i != 2'd1) begin
      in_addr = in_addr + LCD_ROW2_OFFS;
    end
    in_addr = in_addr | LCD_SET_DDRAM;
    // direct digit load for hex and binary
    in_pad = {{MAX_DIGITS{1'b0}}, value_i};
    for (int i = 0; i < int'(MAX_DIGITS); i++) begin
      in_nib[i] = 4'h0;
      if (in_kind == KIND_HEX) begin
        if (i == 0) in_nib[i] = in_pad[3:0];
        if (i == 1) in_nib[i] = in_pad[7:4];
      end else if (in_kind == KIND_BIN) begin
        in_nib[i] = {3'b000, in_pad[i]};
      end
    end
  end

  // Add-3 correction on every BCD digit before each shift
  always_comb begin
    for (int i = 0; i < int'(MAX_DIGITS); i++) begin
      corr[i] = (bcd_q[i] >= 4'd5) ? (bcd_q[i] + 4'd3) : bcd_q[i];
    end
  end

  // Corrected digits shifted left by one, next value bit entering at the bottom
  assign bcd_shift = {corr, bin_q[VALUE_WIDTH-1]};

  // Digit converter: one value bit shifted in per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_cnt_q <= '0;
    end else if (in_accept) begin
      if (in_kind == KIND_UDEC || in_kind == KIND_SDEC) begin
        conv_cnt_q <= ConvW'(VALUE_WIDTH);
      end else begin
        conv_cnt_q <= '0;
      end
    end else if (!conv_done) begin
      conv_cnt_q <= conv_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      bin_q <= in_mag;
      bcd_q <= in_nib;
    end else if (!conv_done) begin
      bcd_q <= bcd_shift[MAX_DIGITS*4-1:0];
      bin_q <= bin_q << 1;
    end
  end

  // Request fields held for the sequencer
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q <= in_kind;
      neg_q  <= in_neg;
      addr_q <= in_addr;
    end
  end

  // Next write selection
  assign dig_idx = IdxW'(dig_q - 1'b1);

  always_comb begin
    emit      = 1'b0;
    emit_data = 1'b1;
    emit_byte = digit_to_ascii(bcd_q[dig_idx]);
    emit_last = (dig_q == CntW'(1));
    state_d   = state_q;
    dig_d     = dig_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_ADDR;
          dig_d   = in_cnt;
        end
      end
      ST_ADDR: begin
        emit      = slot_free;
        emit_data = 1'b0;
        emit_byte = addr_q;
        emit_last = (kind_q != KIND_SDEC) && (dig_q == '0);
        if (emit) begin
          if (emit_last) begin
            state_d = ST_IDLE;
          end else if (kind_q == KIND_SDEC) begin
            state_d = ST_SIGN;
          end else begin
            state_d = ST_DIGITS;
          end
        end
      end
      ST_SIGN: begin
        emit      = slot_free;
        emit_byte = neg_q ? ASCII_MINUS : ASCII_PLUS;
        emit_last = (dig_q == '0);
        if (emit) begin
          state_d = emit_last ? ST_IDLE : ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        emit = slot_free && conv_done;
        if (emit) begin
          dig_d = dig_q - 1'b1;
          if (emit_last) state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      dig_q   <= '0;
    end else begin
      state_q <= state_d;
      dig_q   <= dig_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_is_data_q <= emit_data;
      out_byte_q    <= emit_byte;
      out_last_q    <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign is_data_o   = out_is_data_q;
  assign bus_byte_o  = out_byte_q;
  assign last_o      = out_last_q;

`ifndef SYNTHESIS
  // A taken request always starts with the address command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_ADDR))
    else $error("request taken but sequencer not at address write");

  // Digits leave only once the converter has finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIGITS) && emit |-> conv_done)
    else $error("digit written before conversion finished");

  // The digit phase never runs with an empty digit count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIGITS) |-> (dig_q != '0))
    else $error("digit phase with no digits left");

  // The final write of a request returns the sequencer to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && emit_last |=> (state_q == ST_IDLE))
    else $error("sequencer busy after final write");
`endif

endmodule
